/* rtl/nsrf_pkg.sv */
// shared types, constants and a helper function of the nearest screen region finder
package nsrf_pkg;

  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned SCREEN_W    = 13;
  localparam int unsigned TRIG_W      = 15;
  localparam int unsigned MARGIN_W    = 10;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned PROD_W      = 31;
  localparam int unsigned SQ_W        = 32;
  localparam int unsigned DIST_W      = 34;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 15;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_GAP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILT_COSINE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILT_SINE     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAZE_MARGIN   = 3'd5;

  localparam logic [TRIG_W-1:0]   COSINE_RESET = 15'd16384;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd50;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic               is_query;
    logic               outside;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
    point_t             point;
  } cmd_t;

  // round a Q14 product half away from zero and saturate to 16 bits signed
  function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic [31:0] mag;
    logic [17:0] r;
    logic signed [COORD_W-1:0] res;
    mag = p[PROD_W-1] ? (32'd0 - {1'b1, p}) : {1'b0, p};
    r = 18'((mag + 32'd8192) >> 14);
    if (!p[PROD_W-1]) begin
      res = (r > 18'd32767) ? 16'sh7fff : $signed(r[COORD_W-1:0]);
    end else begin
      res = (r > 18'd32768) ? 16'sh8000 : $signed(16'(18'd0 - r));
    end
    return res;
  endfunction

endpackage

/* rtl/nsrf_queue.sv */
// short command queue between the front and the back
module nsrf_queue
  import nsrf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  cmd_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_PTR_W:0]   fill_q, fill_d;
  logic                   do_push, do_pop;

  assign full_o  = (fill_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/nsrf_front.sv */
// front end: configuration registers, point mapping of loads, outside test of queries
module nsrf_front
  import nsrf_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic                       mode_i,
  input  logic [SLOT_W-1:0]          slot_i,
  input  logic [COUNT_W-1:0]         object_count_i,
  input  logic [SCREEN_W-1:0]        screen_x_i,
  input  logic [SCREEN_W-1:0]        screen_y_i,
  input  logic signed [COORD_W-1:0]  gaze_x_i,
  input  logic signed [COORD_W-1:0]  gaze_y_i,
  input  logic signed [COORD_W-1:0]  gaze_z_i,
  output logic                       cmd_push_o,
  output cmd_t                       cmd_o,
  input  logic                       cmd_full_i
);

  logic [SCREEN_W-1:0] width_q, height_q, gap_q;
  logic [TRIG_W-1:0]   cosine_q, sine_q;
  logic [MARGIN_W-1:0] margin_q;

  logic                      valid_q, valid_d;
  logic                      mode_q;
  logic [SLOT_W-1:0]         slot_q;
  logic [COUNT_W-1:0]        count_q;
  logic [SCREEN_W-1:0]       sx_q;
  logic signed [COORD_W-1:0] gx_q, gy_q, gz_q;
  logic signed [PROD_W-1:0]  prod_y_q, prod_z_q;
  logic [27:0]               hs_q;

  logic                      accept;
  logic signed [14:0]        dist_d;
  logic signed [PROD_W-1:0]  prod_y, prod_z;
  logic [27:0]               hs;
  logic signed [16:0]        x_raw;
  logic signed [COORD_W-1:0] map_x;
  logic signed [16:0]        gz_ext, margin_neg;
  logic signed [31:0]        lhs_z, rhs_z;
  logic signed [17:0]        gx_dbl, bound_x;
  logic                      outside;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      gap_q    <= '0;
      cosine_q <= COSINE_RESET;
      sine_q   <= '0;
      margin_q <= MARGIN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i[SCREEN_W-1:0];
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i[SCREEN_W-1:0];
        CFG_SCREEN_GAP:    gap_q    <= cfg_data_i[SCREEN_W-1:0];
        CFG_TILT_COSINE:   cosine_q <= cfg_data_i[TRIG_W-1:0];
        CFG_TILT_SINE:     sine_q   <= cfg_data_i[TRIG_W-1:0];
        CFG_GAZE_MARGIN:   margin_q <= cfg_data_i[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign full_o     = valid_q && cmd_full_i;
  assign accept     = push_i && !full_o;
  assign cmd_push_o = valid_q;

  // multiplies on the way into the stage register
  assign dist_d = $signed({2'b00, height_q}) - $signed({2'b00, gap_q})
                - $signed({2'b00, screen_y_i});
  assign prod_y = dist_d * $signed({1'b0, cosine_q});
  assign prod_z = dist_d * $signed({1'b0, sine_q});
  assign hs     = height_q * sine_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (!cmd_full_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_i;
      slot_q   <= slot_i;
      count_q  <= object_count_i;
      sx_q     <= screen_x_i;
      gx_q     <= gaze_x_i;
      gy_q     <= gaze_y_i;
      gz_q     <= gaze_z_i;
      prod_y_q <= prod_y;
      prod_z_q <= prod_z;
      hs_q     <= hs;
    end
  end

  assign x_raw = $signed({4'b0000, sx_q}) - $signed({5'b00000, width_q[SCREEN_W-1:1]})
               + $signed({4'b0000, gap_q});

  always_comb begin
    if (x_raw > 17'sd32767) begin
      map_x = 16'sh7fff;
    end else if (x_raw < -17'sd32768) begin
      map_x = 16'sh8000;
    end else begin
      map_x = x_raw[COORD_W-1:0];
    end
  end

  assign gz_ext     = {gz_q[COORD_W-1], gz_q};
  assign margin_neg = -$signed({7'b0000000, margin_q});
  assign lhs_z      = $signed({{2{gz_q[COORD_W-1]}}, gz_q, 14'b0});
  assign rhs_z      = $signed({4'b0000, hs_q}) + $signed({8'b00000000, margin_q, 14'b0});
  assign gx_dbl     = $signed({gx_q[COORD_W-1], gx_q, 1'b0});
  assign bound_x    = $signed({5'b00000, width_q}) + $signed({7'b0000000, margin_q, 1'b0});
  assign outside    = (gz_ext < margin_neg) || (lhs_z > rhs_z)
                   || (gx_dbl > bound_x) || (gx_dbl < -bound_x);

  always_comb begin
    cmd_o.is_query = (mode_q == MODE_QUERY);
    cmd_o.outside  = outside;
    cmd_o.slot     = slot_q;
    cmd_o.count    = count_q;
    if (mode_q == MODE_QUERY) begin
      cmd_o.point.x = gx_q;
      cmd_o.point.y = gy_q;
      cmd_o.point.z = gz_q;
    end else begin
      cmd_o.point.x = map_x;
      cmd_o.point.y = round_sat(prod_y_q);
      cmd_o.point.z = round_sat(prod_z_q);
    end
  end

endmodule

/* rtl/nsrf_back.sv */
// back end: point table, object count and the nearest point scan
module nsrf_back
  import nsrf_pkg::*;
#(
  parameter int unsigned MAX_OBJECTS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [COUNT_W-1:0]  region_index_o,
  output logic                outside_o,
  output logic [DIST_W-1:0]   squared_distance_o
);

  localparam int unsigned IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int unsigned AW    = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  point_t mem [MAX_OBJECTS];
  point_t rd_point_q;

  logic [1:0]         state_q, state_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [COUNT_W-1:0] issue_q, issue_d;
  point_t             gaze_q;
  logic               outside_q;

  logic               rd_v_q, rd_last_q;
  logic [COUNT_W-1:0] rd_idx_q;
  logic               sq_v_q, sq_last_q;
  logic [COUNT_W-1:0] sq_idx_q;
  logic [SQ_W-1:0]    sq_x_q, sq_y_q, sq_z_q;
  logic [DIST_W-1:0]  best_q;
  logic [COUNT_W-1:0] best_idx_q;

  logic               res_valid_q, res_valid_d;
  logic [COUNT_W-1:0] res_idx_q;
  logic               res_out_q;
  logic [DIST_W-1:0]  res_dist_q;

  logic               start, wr_en, rd_en, pop_ok, start_ok, finish, last_issue;
  logic [AW-1:0]      slot_ext, issue_ext;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  logic signed [16:0] dx, dy, dz;
  logic [15:0]        adx, ady, adz;
  logic [DIST_W-1:0]  sum, best_new;
  logic [COUNT_W-1:0] best_idx_new;

  assign pop_ok     = pop_i && res_valid_q;
  assign start_ok   = !res_valid_q || pop_ok;
  assign slot_ext   = AW'(cmd_i.slot);
  assign issue_ext  = AW'(issue_q);
  assign wr_addr    = slot_ext[IDX_W-1:0];
  assign rd_addr    = issue_ext[IDX_W-1:0];
  assign last_issue = (issue_q == cnt_q - 1'b1);
  assign finish     = sq_v_q && sq_last_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    issue_d   = issue_q;
    cmd_pop_o = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    start     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (!cmd_i.is_query) begin
            cmd_pop_o = 1'b1;
            wr_en     = (32'(cmd_i.slot) < MAX_OBJECTS);
            cnt_d     = (32'(cmd_i.count) > MAX_OBJECTS) ? COUNT_W'(MAX_OBJECTS) : cmd_i.count;
          end else if (cnt_q == '0) begin
            cmd_pop_o = 1'b1;
          end else if (start_ok) begin
            cmd_pop_o = 1'b1;
            start     = 1'b1;
            issue_d   = '0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (last_issue) begin
          state_d = ST_WAIT;
        end else begin
          issue_d = issue_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_i.point;
    end
    if (rd_en) begin
      rd_point_q <= mem[rd_addr];
    end
  end

  // distance terms of the entry read in the previous cycle
  assign dx  = {gaze_q.x[COORD_W-1], gaze_q.x} - {rd_point_q.x[COORD_W-1], rd_point_q.x};
  assign dy  = {gaze_q.y[COORD_W-1], gaze_q.y} - {rd_point_q.y[COORD_W-1], rd_point_q.y};
  assign dz  = {gaze_q.z[COORD_W-1], gaze_q.z} - {rd_point_q.z[COORD_W-1], rd_point_q.z};
  assign adx = dx[16] ? 16'(-dx) : dx[15:0];
  assign ady = dy[16] ? 16'(-dy) : dy[15:0];
  assign adz = dz[16] ? 16'(-dz) : dz[15:0];

  assign sum = DIST_W'(sq_x_q) + DIST_W'(sq_y_q) + DIST_W'(sq_z_q);

  always_comb begin
    best_new     = best_q;
    best_idx_new = best_idx_q;
    if (sq_idx_q == '0 || sum < best_q) begin
      best_new     = sum;
      best_idx_new = sq_idx_q;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (finish) begin
      res_valid_d = 1'b1;
    end else if (pop_ok) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      issue_q     <= '0;
      rd_v_q      <= 1'b0;
      sq_v_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      issue_q     <= issue_d;
      rd_v_q      <= rd_en;
      sq_v_q      <= rd_v_q;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      gaze_q    <= cmd_i.point;
      outside_q <= cmd_i.outside;
    end
    rd_idx_q  <= issue_q;
    rd_last_q <= last_issue;
    if (rd_v_q) begin
      sq_x_q    <= adx * adx;
      sq_y_q    <= ady * ady;
      sq_z_q    <= adz * adz;
      sq_idx_q  <= rd_idx_q;
      sq_last_q <= rd_last_q;
    end
    if (sq_v_q) begin
      best_q     <= best_new;
      best_idx_q <= best_idx_new;
    end
    if (finish) begin
      res_idx_q  <= outside_q ? cnt_q : best_idx_new;
      res_out_q  <= outside_q;
      res_dist_q <= best_new;
    end
  end

  assign empty_o            = !res_valid_q;
  assign region_index_o     = res_idx_q;
  assign outside_o          = res_out_q;
  assign squared_distance_o = res_dist_q;

endmodule

/* rtl/nearest_screen_region_finder_core.sv */
// top level of the nearest screen region finder
// Loads and queries enter through a queue-style port (push/full) and results leave through
// another (empty/pop); configuration writes go through a valid/ready port that is always
// ready. A load is mapped onto the tilted screen plane in the front end and written into
// the point table after the front stage register and the queue. In the back end a query
// scans as many table entries as the stored object count, reading one table entry per
// cycle; a new query starts there once the previous scan has ended and its result is
// popped or being popped. A query while the count is zero gives no result. The front end
// keeps accepting items into a two-word queue while the back end scans or a result waits.
module nearest_screen_region_finder_core
  import nsrf_pkg::*;
#(
  parameter int unsigned MAX_OBJECTS = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       push,
  output logic                       full,
  input  logic                       mode_i,
  input  logic [SLOT_W-1:0]          slot_i,
  input  logic [COUNT_W-1:0]         object_count_i,
  input  logic [SCREEN_W-1:0]        screen_x_i,
  input  logic [SCREEN_W-1:0]        screen_y_i,
  input  logic signed [COORD_W-1:0]  gaze_x_i,
  input  logic signed [COORD_W-1:0]  gaze_y_i,
  input  logic signed [COORD_W-1:0]  gaze_z_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [COUNT_W-1:0]         region_index_o,
  output logic                       outside_o,
  output logic [DIST_W-1:0]          squared_distance_o
);

  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;

  assign cfg_ready_o = 1'b1;

  nsrf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push_i         (push),
    .full_o         (full),
    .mode_i         (mode_i),
    .slot_i         (slot_i),
    .object_count_i (object_count_i),
    .screen_x_i     (screen_x_i),
    .screen_y_i     (screen_y_i),
    .gaze_x_i       (gaze_x_i),
    .gaze_y_i       (gaze_y_i),
    .gaze_z_i       (gaze_z_i),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in),
    .cmd_full_i     (cmd_full)
  );

  nsrf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  nsrf_back #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_valid_i        (!cmd_empty),
    .cmd_i              (cmd_out),
    .cmd_pop_o          (cmd_pop),
    .pop_i              (pop),
    .empty_o            (empty),
    .region_index_o     (region_index_o),
    .outside_o          (outside_o),
    .squared_distance_o (squared_distance_o)
  );

endmodule
